/* sv/pkhm_pkg.sv */
package pkhm_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;     // capture the accepted item and clear the result flags
    logic head_rd_hash;  // read the head of the item's bucket
    logic head_rd_idx;   // read the head of the bucket under the sweep index
    logic ptr_from_head; // pointer and saved head take the head read data
    logic ent_rd;        // read the entry under the pointer
    logic ptr_from_link; // pointer follows the link just read
    logic set_hit;       // key found: record it, update value on a store
    logic insert;        // link a new entry at the bucket head
    logic set_full;      // pool exhausted
    logic grow_hold;     // doubling withheld
    logic grow_start;    // double the mask and start redistribution
    logic split_step;    // move one entry to the low or high chain
    logic split_close1;  // write the low chain head and terminate its tail
    logic split_close2;  // write the high chain head and move to next bucket
    logic sweep_clr;     // zero one bucket head and advance the index
    logic pool_reset;    // empty the pool
    logic emit;          // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_fetch;
    logic is_store;
    logic is_clear;
    logic is_nop;
    logic head_zero;
    logic link_zero;
    logic key_match;
    logic pool_exh;
    logic grow_due;
    logic grow_blocked;
    logic sweep_last;
    logic split_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/pkhm_ctrl.sv */
module pkhm_ctrl
  import pkhm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_L_RDH, ST_L_HEAD, ST_L_ERD, ST_L_ENT, ST_MISS, ST_G_CHK,
    ST_SP_RDH, ST_SP_HEAD, ST_SP_ERD, ST_SP_ENT, ST_SP_CL1, ST_SP_CL2, ST_CLR, ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep_clr = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_L_RDH;
        end
      end
      ST_L_RDH: begin
        if (sts_i.is_clear) begin
          state_d = ST_CLR;
        end else if (sts_i.is_nop) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.head_rd_hash = 1'b1;
          state_d = ST_L_HEAD;
        end
      end
      ST_L_HEAD: begin
        cmd_o.ptr_from_head = 1'b1;
        state_d = sts_i.head_zero ? ST_MISS : ST_L_ERD;
      end
      ST_L_ERD: begin
        cmd_o.ent_rd = 1'b1;
        state_d = ST_L_ENT;
      end
      ST_L_ENT: begin
        if (sts_i.key_match) begin
          cmd_o.set_hit = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.ptr_from_link = 1'b1;
          state_d = sts_i.link_zero ? ST_MISS : ST_L_ERD;
        end
      end
      ST_MISS: begin
        if (sts_i.is_fetch) begin
          state_d = ST_DONE;
        end else if (sts_i.pool_exh) begin
          cmd_o.set_full = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.insert = 1'b1;
          state_d = ST_G_CHK;
        end
      end
      ST_G_CHK: begin
        if (!sts_i.grow_due) begin
          state_d = ST_DONE;
        end else if (sts_i.grow_blocked) begin
          cmd_o.grow_hold = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.grow_start = 1'b1;
          state_d = ST_SP_RDH;
        end
      end
      ST_SP_RDH: begin
        cmd_o.head_rd_idx = 1'b1;
        state_d = ST_SP_HEAD;
      end
      ST_SP_HEAD: begin
        cmd_o.ptr_from_head = 1'b1;
        state_d = sts_i.head_zero ? ST_SP_CL1 : ST_SP_ERD;
      end
      ST_SP_ERD: begin
        cmd_o.ent_rd = 1'b1;
        state_d = ST_SP_ENT;
      end
      ST_SP_ENT: begin
        cmd_o.split_step = 1'b1;
        state_d = sts_i.link_zero ? ST_SP_CL1 : ST_SP_ERD;
      end
      ST_SP_CL1: begin
        cmd_o.split_close1 = 1'b1;
        state_d = ST_SP_CL2;
      end
      ST_SP_CL2: begin
        cmd_o.split_close2 = 1'b1;
        state_d = sts_i.split_last ? ST_DONE : ST_SP_RDH;
      end
      ST_CLR: begin
        cmd_o.pool_reset = 1'b1;
        cmd_o.sweep_clr  = 1'b1;
        if (sts_i.sweep_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/pkhm_dp.sv */
module pkhm_dp
  import pkhm_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES    = 1024,
  parameter int unsigned INITIAL_BUCKETS = 512,
  parameter int unsigned MAX_BUCKETS     = 2048,
  parameter int unsigned KEY_BITS        = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] value_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               found_o,
  output logic [VALUE_W-1:0] fetched_value_o,
  output logic               pool_full_o,
  output logic               split_pending_o,
  output logic [COUNT_W-1:0] item_count_o
);

  localparam int unsigned BW = $clog2(MAX_BUCKETS);
  localparam int unsigned EW = $clog2(POOL_ENTRIES);
  localparam int unsigned PW = $clog2(POOL_ENTRIES + 1);

  function automatic logic [BW-1:0] bucket_of(input logic [KEY_BITS-1:0] k,
                                               input logic [BW-1:0] m);
    logic [63:0] kx;
    logic [63:0] h;
    kx = 64'(k);
    h  = (kx >> 3) ^ (kx >> 10) ^ (kx >> 20);
    return h[BW-1:0] & m;
  endfunction

  // Storage
  logic [PW-1:0]       heads_mem [MAX_BUCKETS];
  logic [KEY_BITS-1:0] keys_mem  [POOL_ENTRIES];
  logic [VALUE_W-1:0]  vals_mem  [POOL_ENTRIES];
  logic [PW-1:0]       links_mem [POOL_ENTRIES];

  logic [PW-1:0]       head_rd_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [VALUE_W-1:0]  val_rd_q;
  logic [PW-1:0]       link_rd_q;

  // Control registers
  logic [BW-1:0] idx_q, mask_q, old_q;
  logic [PW-1:0] nf_q, held_q;
  logic          split_q, hold_q, out_valid_q;
  // Payload registers
  logic [FUNC_W-1:0]   func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VALUE_W-1:0]  val_q;
  logic [PW-1:0]       p_q, head_q, keep_q, tail_q, hi_q;
  logic                found_q, full_q;
  logic [VALUE_W-1:0]  fetched_q;
  logic                res_found_q, res_full_q, res_split_q;
  logic [VALUE_W-1:0]  res_val_q;
  logic [COUNT_W-1:0]  res_cnt_q;

  logic [BW-1:0] bucket_w, new_bucket_w;
  logic [EW-1:0] p_idx_w, tail_idx_w, nf_idx_w;
  logic [31:0]   held_ext_w;

  assign bucket_w     = bucket_of(key_q, mask_q);
  assign new_bucket_w = bucket_of(key_rd_q, mask_q);
  assign p_idx_w      = EW'(p_q - 1'b1);
  assign tail_idx_w   = EW'(tail_q - 1'b1);
  assign nf_idx_w     = EW'(nf_q);
  assign held_ext_w   = 32'(held_q);

  // Bucket head memory: one write and one read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_clr) begin
      heads_mem[idx_q] <= '0;
    end else if (cmd_i.insert) begin
      heads_mem[bucket_w] <= PW'(nf_q + 1'b1);
    end else if (cmd_i.split_close1) begin
      heads_mem[idx_q] <= keep_q;
    end else if (cmd_i.split_close2) begin
      heads_mem[BW'(idx_q + old_q)] <= hi_q;
    end
    if (cmd_i.head_rd_hash) begin
      head_rd_q <= heads_mem[bucket_w];
    end else if (cmd_i.head_rd_idx) begin
      head_rd_q <= heads_mem[idx_q];
    end
  end

  // Entry pool memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      keys_mem[nf_idx_w] <= key_q;
      vals_mem[nf_idx_w] <= val_q;
    end else if (cmd_i.set_hit && func_q == FUNC_STORE) begin
      vals_mem[p_idx_w] <= val_q;
    end
    if (cmd_i.insert) begin
      links_mem[nf_idx_w] <= head_q;
    end else if (cmd_i.split_step) begin
      if (new_bucket_w != idx_q) begin
        links_mem[p_idx_w] <= hi_q;
      end else if (tail_q != '0) begin
        links_mem[tail_idx_w] <= p_q;
      end
    end else if (cmd_i.split_close1 && tail_q != '0) begin
      links_mem[tail_idx_w] <= '0;
    end
    if (cmd_i.ent_rd) begin
      key_rd_q  <= keys_mem[p_idx_w];
      val_rd_q  <= vals_mem[p_idx_w];
      link_rd_q <= links_mem[p_idx_w];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      mask_q      <= BW'(INITIAL_BUCKETS - 1);
      old_q       <= '0;
      nf_q        <= '0;
      held_q      <= '0;
      split_q     <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) hold_q <= cfg_wdata_i;
      if (cmd_i.load_item) begin
        idx_q <= '0;
      end else if (cmd_i.sweep_clr || cmd_i.split_close2) begin
        idx_q <= BW'(idx_q + 1'b1);
      end else if (cmd_i.grow_start) begin
        idx_q <= '0;
      end
      if (cmd_i.grow_start) begin
        old_q   <= BW'(mask_q + 1'b1);
        mask_q  <= BW'({mask_q, 1'b1});
        split_q <= 1'b0;
      end
      if (cmd_i.grow_hold) split_q <= 1'b1;
      if (cmd_i.pool_reset) begin
        nf_q   <= '0;
        held_q <= '0;
      end else if (cmd_i.insert) begin
        nf_q   <= PW'(nf_q + 1'b1);
        held_q <= PW'(held_q + 1'b1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q    <= func_i;
      key_q     <= KEY_BITS'(key_i);
      val_q     <= value_i;
      found_q   <= 1'b0;
      full_q    <= 1'b0;
      fetched_q <= '0;
    end
    if (cmd_i.ptr_from_head) begin
      p_q    <= head_rd_q;
      head_q <= head_rd_q;
    end else if (cmd_i.ptr_from_link || cmd_i.split_step) begin
      p_q <= link_rd_q;
    end
    if (cmd_i.set_hit) begin
      found_q <= 1'b1;
      if (func_q == FUNC_FETCH) fetched_q <= val_rd_q;
    end
    if (cmd_i.set_full) full_q <= 1'b1;
    if (cmd_i.grow_start || cmd_i.split_close2) begin
      keep_q <= '0;
      tail_q <= '0;
      hi_q   <= '0;
    end else if (cmd_i.split_step) begin
      if (new_bucket_w != idx_q) begin
        hi_q <= p_q;
      end else begin
        if (tail_q == '0) keep_q <= p_q;
        tail_q <= p_q;
      end
    end
    if (cmd_i.emit) begin
      res_found_q <= found_q;
      res_val_q   <= fetched_q;
      res_full_q  <= full_q;
      res_split_q <= split_q;
      res_cnt_q   <= held_ext_w[COUNT_W-1:0];
    end
  end

  always_comb begin
    sts_o.is_fetch     = (func_q == FUNC_FETCH);
    sts_o.is_store     = (func_q == FUNC_STORE);
    sts_o.is_clear     = (func_q == FUNC_CLEAR);
    sts_o.is_nop       = (func_q == FUNC_NOP);
    sts_o.head_zero    = (head_rd_q == '0);
    sts_o.link_zero    = (link_rd_q == '0);
    sts_o.key_match    = (key_rd_q == key_q);
    sts_o.pool_exh     = (32'(nf_q) >= POOL_ENTRIES);
    sts_o.grow_due     = (head_q != '0) && (held_ext_w > 32'(mask_q));
    sts_o.grow_blocked = hold_q || ((32'(mask_q) + 32'd1) * 32'd2 > MAX_BUCKETS);
    sts_o.sweep_last   = (idx_q == BW'(MAX_BUCKETS - 1));
    sts_o.split_last   = (idx_q == BW'(old_q - 1'b1));
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = res_found_q;
  assign fetched_value_o = res_val_q;
  assign pool_full_o     = res_full_q;
  assign split_pending_o = res_split_q;
  assign item_count_o    = res_cnt_q;

`ifndef SYNTHESIS
  a_count_tracks_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == nf_q) else $error("entry count differs from pool fill");
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= POOL_ENTRIES) else $error("entry count beyond pool size");
  a_mask_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mask_q + 1'b1) & mask_q) == '0) else $error("bucket mask not one below a power of two");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> !sts_o.pool_exh) else $error("insert into full pool");
`endif

endmodule

/* sv/pointer_key_hash_map_core.sv */
// A fetch or store walks its bucket's chain entry by entry, then loads its result; a miss
// passes through one more state, and linking in a new entry adds the growth check. The
// next item can be accepted in the cycle after the result is loaded. A doubling visits
// every old bucket and every entry. Clear sweeps every bucket head; one item is in flight
// at a time. After reset all bucket heads are cleared while s_axis_tready stays low;
// configuration writes are taken throughout.
module pointer_key_hash_map_core
  import pkhm_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES    = 1024,
  parameter int unsigned INITIAL_BUCKETS = 512,
  parameter int unsigned MAX_BUCKETS     = 2048,
  parameter int unsigned KEY_BITS        = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: bit 0 is split_hold.
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  // Input items.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // key [63:0], value [127:64]
  input  logic [1:0]   s_axis_tuser,  // func [1:0]
  // Result items.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // fetched_value [63:0], item_count [74:64], zeros
  output logic [2:0]   m_axis_tuser   // found [0], pool_full [1], split_pending [2]
);

  // The controller steps through lookup, insertion, bucket doubling and the
  // clearing sweep; the datapath holds the memories and the map's registers.
  cmd_t cmd;
  sts_t sts;

  logic               found;
  logic [VALUE_W-1:0] fetched_value;
  logic               pool_full;
  logic               split_pending;
  logic [COUNT_W-1:0] item_count;

  pkhm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pkhm_dp #(
    .POOL_ENTRIES    (POOL_ENTRIES),
    .INITIAL_BUCKETS (INITIAL_BUCKETS),
    .MAX_BUCKETS     (MAX_BUCKETS),
    .KEY_BITS        (KEY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (s_axis_tuser),
    .key_i           (s_axis_tdata[63:0]),
    .value_i         (s_axis_tdata[127:64]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .found_o         (found),
    .fetched_value_o (fetched_value),
    .pool_full_o     (pool_full),
    .split_pending_o (split_pending),
    .item_count_o    (item_count)
  );

  // The result item sits in the output register, so the controller can take
  // the next item while this one waits to be taken.
  assign m_axis_tdata = {5'd0, item_count, fetched_value};
  assign m_axis_tuser = {split_pending, pool_full, found};

endmodule

/* tb/pointer_key_hash_map_core_tb.sv */
`timescale 1ns / 100ps

module pointer_key_hash_map_core_tb;
  import pkhm_pkg::*;

  localparam int unsigned POOL_SIZE  = 1024;
  localparam int unsigned BUCKET_MAX = 2048;
  localparam int unsigned CYCLE_CAP  = 3000000;
  // The slowest single item is a doubling to the largest table.
  localparam int unsigned SETTLE_CYCLES = 8000;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } map_op_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] fetched;
    logic               pool_full;
    logic               split_pending;
    logic [COUNT_W-1:0] count;
  } map_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_wdata_i = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  pointer_key_hash_map_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the table. Heads and links hold entry index + 1, with 0 as null.
  int unsigned        shadow_heads [BUCKET_MAX];
  logic [KEY_W-1:0]   shadow_keys  [POOL_SIZE];
  logic [VALUE_W-1:0] shadow_vals  [POOL_SIZE];
  int unsigned        shadow_links [POOL_SIZE];
  int unsigned        next_free;
  int unsigned        held;
  int unsigned        mask;
  logic               split_wanted;
  logic               split_hold;

  map_op_t     pending_ops [$];
  map_result_t expected_results [$];
  logic [KEY_W-1:0] live_keys [$];   // keys the stimulus may hit again

  map_op_t     cur_op;
  logic        op_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_off = 0;          // long receiver stall, counted down on its own
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic int unsigned bucket_of(logic [KEY_W-1:0] k, int unsigned m);
    logic [KEY_W-1:0] h;
    h = (k >> 3) ^ (k >> 10) ^ (k >> 20);
    return int'(h[10:0]) & m;
  endfunction

  function automatic int unsigned find_entry(logic [KEY_W-1:0] k);
    int unsigned p;
    int unsigned steps;
    p = shadow_heads[bucket_of(k, mask)];
    steps = 0;
    while (p != 0 && steps < POOL_SIZE) begin
      if (shadow_keys[p-1] == k) return p;
      p = shadow_links[p-1];
      steps++;
    end
    return 0;
  endfunction

  // Double the bucket array (unless held or already at the largest size) and split every chain
  // between bucket i and i + old size, keeping the order of the entries that stay low.
  task automatic double_buckets();
    int unsigned old_size;
    int unsigned new_mask;
    int unsigned keep;
    int unsigned keep_tail;
    int unsigned p;
    int unsigned nxt;
    old_size = mask + 1;
    if (split_hold || old_size * 2 > BUCKET_MAX) begin
      split_wanted = 1'b1;
      return;
    end
    split_wanted = 1'b0;
    new_mask = old_size * 2 - 1;
    for (int unsigned i = old_size; i <= new_mask; i++) shadow_heads[i] = '0;
    mask = new_mask;
    for (int unsigned i = 0; i < old_size; i++) begin
      keep = 0;
      keep_tail = 0;
      p = shadow_heads[i];
      while (p != 0) begin
        nxt = shadow_links[p-1];
        if (bucket_of(shadow_keys[p-1], new_mask) != i) begin
          shadow_links[p-1] = shadow_heads[i + old_size];
          shadow_heads[i + old_size] = p;
        end else begin
          shadow_links[p-1] = '0;
          if (keep_tail == 0) keep = p;
          else shadow_links[keep_tail-1] = p;
          keep_tail = p;
        end
        p = nxt;
      end
      shadow_heads[i] = keep;
    end
  endtask

  task automatic apply_map_op(input map_op_t op, output map_result_t res);
    int unsigned p;
    int unsigned b;
    int unsigned e;
    res = '0;
    case (op.func)
      FUNC_FETCH: begin
        p = find_entry(op.key);
        if (p != 0) begin
          res.found = 1'b1;
          res.fetched = shadow_vals[p-1];
        end
      end
      FUNC_STORE: begin
        p = find_entry(op.key);
        if (p != 0) begin
          res.found = 1'b1;
          shadow_vals[p-1] = op.value;
        end else if (next_free >= POOL_SIZE) begin
          res.pool_full = 1'b1;
        end else begin
          b = bucket_of(op.key, mask);
          e = next_free++;
          shadow_keys[e] = op.key;
          shadow_vals[e] = op.value;
          shadow_links[e] = shadow_heads[b];
          shadow_heads[b] = e + 1;
          held++;
          // Only an insert into an occupied bucket can trigger a doubling.
          if (shadow_links[e] != 0 && held > mask) double_buckets();
        end
      end
      FUNC_CLEAR: begin
        for (int unsigned i = 0; i < BUCKET_MAX; i++) shadow_heads[i] = '0;
        next_free = 0;
        held = 0;
      end
      default: ;
    endcase
    res.split_pending = split_wanted;
    res.count = held[COUNT_W-1:0];
  endtask

  // Random operation mix; store_pct sets how fast the table fills.
  function automatic map_op_t random_op(int unsigned store_pct);
    map_op_t op;
    int unsigned r;
    op.key = {$urandom, $urandom};
    op.value = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < store_pct) begin
      op.func = FUNC_STORE;
      live_keys.push_back(op.key);
    end else if (r < store_pct + 8 && live_keys.size() > 0) begin
      op.func = FUNC_STORE;
      op.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
    end else if (r < 96 && live_keys.size() > 0) begin
      op.func = FUNC_FETCH;
      op.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
    end else if (r < 98) begin
      op.func = FUNC_FETCH;
    end else begin
      op.func = FUNC_NOP;
    end
    return op;
  endfunction

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Shadow state and the handshake monitors. Inputs are sampled at the rising edge.
  initial begin
    for (int unsigned i = 0; i < BUCKET_MAX; i++) shadow_heads[i] = '0;
    next_free = 0;
    held = 0;
    mask = 511;
    split_wanted = 1'b0;
    split_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    map_result_t exp_res;
    map_result_t got_res;
    cycles++;
    if (cfg_we_i) split_hold = cfg_wdata_i;
    if (s_axis_tvalid && s_axis_tready) begin
      apply_map_op(cur_op, exp_res);
      expected_results.push_back(exp_res);
      op_taken <= 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got_res.found = m_axis_tuser[0];
      got_res.pool_full = m_axis_tuser[1];
      got_res.split_pending = m_axis_tuser[2];
      got_res.fetched = m_axis_tdata[63:0];
      got_res.count = m_axis_tdata[74:64];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got_res);
      end else begin
        exp_res = expected_results.pop_front();
        if (got_res !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_res, got_res);
        end
      end
    end
    if (cycles >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Sender: presents the next pending item after a random gap, changing at the falling edge.
  always @(negedge clk_i) begin
    logic offer;
    offer = s_axis_tvalid && !op_taken;
    if (op_taken) begin
      op_taken <= 1'b0;
      send_gap = random_gap();
    end
    if (!offer) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        offer = 1'b1;
      end
    end
    s_axis_tvalid <= offer;
    s_axis_tdata <= offer ? {cur_op.value, cur_op.key} : '0;
    s_axis_tuser <= offer ? cur_op.func : '0;
  end

  // Receiver: random stalls, and the long hold-off when one is armed.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = random_gap();
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  // Register writes only go in while the block is idle.
  task automatic write_split_hold(input logic hold);
    wait_drained();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hold;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                          input logic [VALUE_W-1:0] v);
    map_op_t op;
    op.func = f;
    op.key = k;
    op.value = v;
    pending_ops.push_back(op);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: misses, insert, update of a present key, extremes, no-op, clear.
    queue_op(FUNC_FETCH, 64'h0, 64'h0);
    queue_op(FUNC_STORE, 64'h0, {VALUE_W{1'b1}});
    queue_op(FUNC_FETCH, 64'h0, 64'h0);
    queue_op(FUNC_STORE, {KEY_W{1'b1}}, 64'h0);
    queue_op(FUNC_FETCH, {KEY_W{1'b1}}, 64'h0);
    queue_op(FUNC_STORE, 64'h0, 64'h1234_5678_9abc_def0);
    queue_op(FUNC_FETCH, 64'h0, {VALUE_W{1'b1}});
    // Keys 8 and 2**30 + 8 share a bucket, so the second one builds a chain.
    queue_op(FUNC_STORE, 64'h8, 64'h5555_5555_5555_5555);
    queue_op(FUNC_STORE, 64'h4000_0008, 64'haaaa_aaaa_aaaa_aaaa);
    queue_op(FUNC_FETCH, 64'h8, 64'h0);
    queue_op(FUNC_FETCH, 64'h4000_0008, 64'h0);
    queue_op(FUNC_NOP, {KEY_W{1'b1}}, {VALUE_W{1'b1}});
    queue_op(FUNC_CLEAR, {KEY_W{1'b1}}, {VALUE_W{1'b1}});
    queue_op(FUNC_FETCH, 64'h0, 64'h0);
    queue_op(FUNC_FETCH, 64'h8, 64'h0);

    // Doubling withheld: the table fills past the mask with split_hold set.
    write_split_hold(1'b1);
    queue_op(FUNC_CLEAR, 64'h0, 64'h0);
    live_keys.delete();
    for (int i = 0; i < 560; i++) pending_ops.push_back(random_op(96));

    // Hold the receiver off for a long stretch while the sender keeps offering.
    wait (pending_ops.size() < 480);
    hold_off = 400;

    // Release the hold: the next insert into an occupied bucket doubles the buckets.
    write_split_hold(1'b0);
    for (int i = 0; i < 60; i++) pending_ops.push_back(random_op(85));

    // Light traffic on a cleared table that keeps the large mask.
    write_split_hold(1'b1);
    queue_op(FUNC_CLEAR, 64'h0, 64'h0);
    live_keys.delete();
    for (int i = 0; i < 30; i++) pending_ops.push_back(random_op(40));

    write_split_hold(1'b0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
